FILE: src/tvp_pkg.sv
// ----------------------------------------------------------------------------
// tvp_pkg
// Shared codes, command/status types and the divide-by-tick helper for the
// trapezoid velocity profiler.
// ----------------------------------------------------------------------------
package tvp_pkg;

  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_STRAIGHT = 2'd1;
  localparam logic [1:0] OP_CW       = 2'd2;
  localparam logic [1:0] OP_CCW      = 2'd3;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_UP     = 3'd1;
  localparam logic [2:0] PH_STEADY = 3'd2;
  localparam logic [2:0] PH_DOWN   = 3'd3;
  localparam logic [2:0] PH_FINAL  = 3'd4;

  localparam logic [2:0] CFG_LIN_TOP  = 3'd0;
  localparam logic [2:0] CFG_ANG_TOP  = 3'd1;
  localparam logic [2:0] CFG_LIN_UP   = 3'd2;
  localparam logic [2:0] CFG_LIN_DOWN = 3'd3;
  localparam logic [2:0] CFG_ANG_UP   = 3'd4;
  localparam logic [2:0] CFG_ANG_DOWN = 3'd5;

  localparam int unsigned TICK_MS  = 100;
  localparam int unsigned DIV_BITS = 32;
  localparam int unsigned CNT_W    = $clog2(DIV_BITS) + 1;

  // floor(x / 100) for x < 2**17: reciprocal 2**24/100 rounded up
  localparam logic [17:0] TICK_RECIP = 18'd167773;
  localparam int unsigned RECIP_SH   = 24;

  typedef struct packed {
    logic [15:0] lin_top;
    logic [15:0] ang_top;
    logic [15:0] lin_up;
    logic [15:0] lin_down;
    logic [15:0] ang_up;
    logic [15:0] ang_down;
  } tvp_cfg_t;

  typedef struct packed {
    logic load_item;
    logic start;
    logic mul;
    logic div_step;
    logic emit;
  } tvp_cmd_t;

  typedef struct packed {
    logic phase_idle;
    logic div_done;
    logic out_free;
  } tvp_stat_t;

  function automatic logic [15:0] div_tick(input logic [16:0] x);
    logic [34:0] prod;
    prod = {18'd0, x} * {17'd0, TICK_RECIP};
    return {5'd0, prod[RECIP_SH +: 11]};
  endfunction

endpackage

FILE: src/tvp_if.sv
// ----------------------------------------------------------------------------
// tvp_if
// Valid/ready channels of the trapezoid velocity profiler: command input,
// sample output and register write.
// ----------------------------------------------------------------------------
interface tvp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] move_length_ms;
  modport source (output valid, operation, move_length_ms, input ready);
  modport sink   (input valid, operation, move_length_ms, output ready);
endinterface

interface tvp_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] linear_velocity;
  logic signed [16:0] angular_velocity;
  logic               busy_res;
  logic               last_sample;
  logic               rejected;
  modport source (output valid, linear_velocity, angular_velocity, busy_res,
                  last_sample, rejected, input ready);
  modport sink   (input valid, linear_velocity, angular_velocity, busy_res,
                  last_sample, rejected, output ready);
endinterface

interface tvp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/trapezoid_velocity_profiler_core.sv
// ----------------------------------------------------------------------------
// trapezoid_velocity_profiler_core
// Trapezoidal velocity profile generator: start commands set up a straight
// or turning motion; a 100 ms tick word in a profile gives one velocity sample.
// ----------------------------------------------------------------------------
// One word is taken at a time. A start command (accepted or rejected) gives
// its result word from the start state, which loads the output register
// once it is free; the input is ready again after that. A tick during a
// running profile goes through the top*index multiply, 32 iterations of
// the bit-serial restoring divider plus a completion state, and the load of
// the output register. A tick while no profile runs is consumed without a
// result and the input is ready again in the next cycle. A result waits in
// the output register while the next word is taken; a held output stalls
// only the next result load.
module trapezoid_velocity_profiler_core
  import tvp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  tvp_in_if.sink   in_ch,
  tvp_out_if.source out_ch,
  tvp_cfg_if.sink  cfg
);

  tvp_cfg_t  cfg_regs;
  tvp_cmd_t  cmd;
  tvp_stat_t stat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_LIN_TOP:  cfg_regs.lin_top  <= cfg.data;
        CFG_ANG_TOP:  cfg_regs.ang_top  <= cfg.data;
        CFG_LIN_UP:   cfg_regs.lin_up   <= cfg.data;
        CFG_LIN_DOWN: cfg_regs.lin_down <= cfg.data;
        CFG_ANG_UP:   cfg_regs.ang_up   <= cfg.data;
        CFG_ANG_DOWN: cfg_regs.ang_down <= cfg.data;
        default:      ;
      endcase
    end
  end

  tvp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .operation (in_ch.operation),
    .in_ready  (in_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tvp_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_regs         (cfg_regs),
    .cmd              (cmd),
    .stat             (stat),
    .operation        (in_ch.operation),
    .move_length_ms   (in_ch.move_length_ms),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .linear_velocity  (out_ch.linear_velocity),
    .angular_velocity (out_ch.angular_velocity),
    .busy_res         (out_ch.busy_res),
    .last_sample      (out_ch.last_sample),
    .rejected         (out_ch.rejected)
  );

  a_busy_after_word: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready &&
     (in_ch.operation != OP_TICK || !stat.phase_idle)) |=> !in_ch.ready)
    else $error("input ready while a word is in progress");

  a_one_axis: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.linear_velocity == 17'sd0 ||
                      out_ch.angular_velocity == 17'sd0))
    else $error("both velocity axes driven");

  a_final_word: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.last_sample) |->
      (!out_ch.busy_res && !out_ch.rejected &&
       out_ch.linear_velocity == 17'sd0 && out_ch.angular_velocity == 17'sd0))
    else $error("final sample not a clean stop");

  a_final_goes_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && stat.phase_idle |=> 1'b0)
    else $error("sample emitted with no running profile");

endmodule

FILE: src/tvp_ctrl.sv
// ----------------------------------------------------------------------------
// tvp_ctrl
// Sequencer: takes one word at a time, runs the multiply and divider
// iterations for a tick and hands the result to the output register.
// ----------------------------------------------------------------------------
module tvp_ctrl
  import tvp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] operation,
  output logic       in_ready,
  input  tvp_stat_t  stat,
  output tvp_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (operation != OP_TICK) begin
            state_next = S_START;
          end else if (!stat.phase_idle) begin
            state_next = S_MUL;
          end
        end
      end
      S_START: begin
        if (stat.out_free) begin
          cmd.start  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_EMIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/tvp_datapath.sv
// ----------------------------------------------------------------------------
// tvp_datapath
// Profile state, ramp multiplier, bit-serial restoring divider and the
// output register.
// ----------------------------------------------------------------------------
module tvp_datapath
  import tvp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  tvp_cfg_t           cfg_regs,
  input  tvp_cmd_t           cmd,
  output tvp_stat_t          stat,
  input  logic [1:0]         operation,
  input  logic [15:0]        move_length_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] linear_velocity,
  output logic signed [16:0] angular_velocity,
  output logic               busy_res,
  output logic               last_sample,
  output logic               rejected
);

  logic [2:0]  phase, phase_next;
  logic [1:0]  motion_kind, motion_kind_next;
  logic [15:0] sample_index, sample_index_next;
  logic [15:0] ramp_steps, ramp_steps_next;
  logic [15:0] steady_left, steady_left_next;
  logic [15:0] down_ramp_ms, down_ramp_ms_next;
  logic [CNT_W-1:0] count;

  logic [1:0]  op_q;
  logic [15:0] len_q;
  logic [31:0] quo;
  logic [15:0] rem;

  logic [15:0] top, factor, up, down, mag, steady_dec;
  logic [16:0] sum, len17, mag17;
  logic [14:0] half;
  logic [17:0] trial;
  logic        load_out, do_start;
  logic signed [16:0] lin_next, ang_next;
  logic        busy_next, last_next, rej_next;

  assign top    = (motion_kind == OP_STRAIGHT) ? cfg_regs.lin_top : cfg_regs.ang_top;
  assign factor = (phase == PH_DOWN) ? ramp_steps - sample_index : sample_index;
  assign up     = (op_q == OP_STRAIGHT) ? cfg_regs.lin_up : cfg_regs.ang_up;
  assign down   = (op_q == OP_STRAIGHT) ? cfg_regs.lin_down : cfg_regs.ang_down;
  assign sum    = {1'b0, up} + {1'b0, down};
  assign len17  = {1'b0, len_q};
  assign half   = len_q[15:1];
  assign trial  = {1'b0, rem, quo[DIV_BITS-1]} - {2'b0, ramp_steps};
  assign steady_dec = steady_left - {15'd0, (steady_left != 16'd0)};

  assign stat.phase_idle = (phase == PH_IDLE);
  assign stat.div_done   = count[CNT_W-1];
  assign stat.out_free   = !out_valid || out_ready;

  assign do_start = cmd.start && (phase == PH_IDLE);
  assign load_out = cmd.start || cmd.emit;

  always_comb begin
    phase_next        = phase;
    motion_kind_next  = motion_kind;
    sample_index_next = sample_index;
    ramp_steps_next   = ramp_steps;
    steady_left_next  = steady_left;
    down_ramp_ms_next = down_ramp_ms;
    mag               = '0;
    busy_next         = 1'b1;
    last_next         = 1'b0;
    rej_next          = 1'b0;

    if (cmd.start) begin
      rej_next = !do_start;
    end
    if (do_start) begin
      motion_kind_next  = op_q;
      sample_index_next = '0;
      phase_next        = PH_UP;
      if (len17 <= sum) begin
        ramp_steps_next   = div_tick({2'b0, half});
        down_ramp_ms_next = len_q - {1'b0, half};
        steady_left_next  = '0;
      end else begin
        ramp_steps_next   = div_tick({1'b0, up});
        down_ramp_ms_next = down;
        steady_left_next  = div_tick(len17 - sum + 17'(TICK_MS - 1));
      end
    end

    if (cmd.emit) begin
      case (phase)
        PH_UP: begin
          mag = (ramp_steps == 16'd0) ? 16'd0 : quo[15:0];
          if (sample_index >= ramp_steps) begin
            if (steady_left != 16'd0) begin
              phase_next = PH_STEADY;
            end else begin
              phase_next        = PH_DOWN;
              sample_index_next = '0;
              ramp_steps_next   = div_tick({1'b0, down_ramp_ms});
            end
          end else begin
            sample_index_next = sample_index + 16'd1;
          end
        end
        PH_STEADY: begin
          mag              = top;
          steady_left_next = steady_dec;
          if (steady_dec == 16'd0) begin
            phase_next        = PH_DOWN;
            sample_index_next = '0;
            ramp_steps_next   = div_tick({1'b0, down_ramp_ms});
          end
        end
        PH_DOWN: begin
          mag = (ramp_steps == 16'd0) ? 16'd0 : quo[15:0];
          if (sample_index >= ramp_steps) begin
            phase_next = PH_FINAL;
          end else begin
            sample_index_next = sample_index + 16'd1;
          end
        end
        PH_FINAL: begin
          busy_next         = 1'b0;
          last_next         = 1'b1;
          phase_next        = PH_IDLE;
          sample_index_next = '0;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  assign mag17 = {1'b0, mag};

  always_comb begin
    lin_next = '0;
    ang_next = '0;
    if (cmd.emit) begin
      case (motion_kind)
        OP_STRAIGHT: lin_next = signed'(mag17);
        OP_CW:       ang_next = signed'(17'd0 - mag17);
        OP_CCW:      ang_next = signed'(mag17);
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      motion_kind  <= OP_TICK;
      sample_index <= '0;
      ramp_steps   <= '0;
      steady_left  <= '0;
      down_ramp_ms <= '0;
      count        <= '0;
      out_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      motion_kind  <= motion_kind_next;
      sample_index <= sample_index_next;
      ramp_steps   <= ramp_steps_next;
      steady_left  <= steady_left_next;
      down_ramp_ms <= down_ramp_ms_next;
      if (cmd.mul) begin
        count <= '0;
      end else if (cmd.div_step) begin
        count <= count + CNT_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q  <= operation;
      len_q <= move_length_ms;
    end
    if (cmd.mul) begin
      quo <= {16'd0, top} * {16'd0, factor};
      rem <= '0;
    end else if (cmd.div_step) begin
      if (!trial[17]) begin
        rem <= trial[15:0];
        quo <= {quo[DIV_BITS-2:0], 1'b1};
      end else begin
        rem <= {rem[14:0], quo[DIV_BITS-1]};
        quo <= {quo[DIV_BITS-2:0], 1'b0};
      end
    end
    if (load_out) begin
      linear_velocity  <= lin_next;
      angular_velocity <= ang_next;
      busy_res         <= busy_next;
      last_sample      <= last_next;
      rejected         <= rej_next;
    end
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the trapezoid velocity profiler core. A short
// stimulus table covers the idle tick, a busy start, zero-step ramps and
// the speed extremes. Randomized phases follow, each with its own register
// settings. Every result word is checked against its table row or an in-bench
// profile model, with random stalls on both channels and one long output hold.
// ----------------------------------------------------------------------------
module testbench;
  import tvp_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned SETTLE      = 60;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_WORDS = 100;
  localparam int unsigned TABLE_ROWS  = 25;

  typedef struct packed {
    logic signed [16:0] lin;
    logic signed [16:0] ang;
    logic               busy;
    logic               last;
    logic               rej;
  } sample_t;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] len;
    bit          typed;
    bit          has_res;
    sample_t     want;
  } stim_row_t;

  localparam sample_t S_NONE   = '0;
  localparam sample_t S_RUN0   = {17'sd0, 17'sd0, 3'b100};
  localparam sample_t S_REJECT = {17'sd0, 17'sd0, 3'b101};
  localparam sample_t S_DONE   = {17'sd0, 17'sd0, 3'b010};

  logic clk;
  logic rst;

  tvp_in_if  in_ch();
  tvp_out_if out_ch();
  tvp_cfg_if cfg_ch();

  trapezoid_velocity_profiler_core uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  tvp_cfg_t    limits;
  logic [2:0]  ph;
  logic [1:0]  kind;
  int unsigned idx;
  int unsigned steps;
  int unsigned steady_left;
  int unsigned down_ms;

  sample_t     sample_q[$];
  int unsigned mismatches;
  int unsigned stall_cnt;
  bit          quiet;
  bit          calm;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned scale(input int unsigned top, input int unsigned factor,
                                        input int unsigned div);
    return (div == 0) ? 0 : (top * factor) / div;
  endfunction

  function automatic sample_t shape(input int unsigned mag, input logic busy,
                                    input logic last);
    sample_t    s;
    logic [16:0] m17;
    s = '0;
    m17 = mag[16:0];
    s.busy = busy;
    s.last = last;
    case (kind)
      OP_STRAIGHT: s.lin = m17;
      OP_CW:       s.ang = ~m17 + 17'd1;
      OP_CCW:      s.ang = m17;
      default: ;
    endcase
    return s;
  endfunction

  function automatic void enter_down();
    ph = PH_DOWN;
    idx = 0;
    steps = down_ms / TICK_MS;
  endfunction

  // advances the profile by one word; returns 1 when the word yields a sample
  function automatic bit profile_next(input logic [1:0] op, input logic [15:0] len,
                                      output sample_t s);
    int unsigned up;
    int unsigned dn;
    int unsigned top;
    int unsigned mag;
    s = '0;
    if (op != OP_TICK) begin
      s.busy = 1'b1;
      if (ph != PH_IDLE) begin
        s.rej = 1'b1;
        return 1'b1;
      end
      kind = op;
      if (op == OP_STRAIGHT) begin
        up = limits.lin_up;
        dn = limits.lin_down;
      end else begin
        up = limits.ang_up;
        dn = limits.ang_down;
      end
      if (len <= up + dn) begin
        steps = (len / 2) / TICK_MS;
        down_ms = len - len / 2;
        steady_left = 0;
      end else begin
        steps = up / TICK_MS;
        down_ms = dn;
        steady_left = (len - up - dn + TICK_MS - 1) / TICK_MS;
      end
      idx = 0;
      ph = PH_UP;
      return 1'b1;
    end
    top = (kind == OP_STRAIGHT) ? limits.lin_top : limits.ang_top;
    case (ph)
      PH_UP: begin
        s = shape(scale(top, idx, steps), 1'b1, 1'b0);
        if (idx >= steps) begin
          if (steady_left != 0) ph = PH_STEADY;
          else enter_down();
        end else begin
          idx++;
        end
        return 1'b1;
      end
      PH_STEADY: begin
        s = shape(top, 1'b1, 1'b0);
        if (steady_left > 0) steady_left--;
        if (steady_left == 0) enter_down();
        return 1'b1;
      end
      PH_DOWN: begin
        mag = (idx <= steps) ? scale(top, steps - idx, steps) : 0;
        s = shape(mag, 1'b1, 1'b0);
        if (idx >= steps) ph = PH_FINAL;
        else idx++;
        return 1'b1;
      end
      PH_FINAL: begin
        s = shape(0, 1'b0, 1'b1);
        ph = PH_IDLE;
        idx = 0;
        return 1'b1;
      end
      default: begin
        ph = PH_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic stim_row_t row(input logic [1:0] op, input logic [15:0] len,
                                    input bit typed, input bit has_res, input sample_t want);
    stim_row_t r;
    r.op = op;
    r.len = len;
    r.typed = typed;
    r.has_res = has_res;
    r.want = want;
    return r;
  endfunction

  function automatic logic [15:0] pick_ramp();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2500));
  endfunction

  task automatic gap();
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic send_word(input logic [1:0] op, input logic [15:0] len, input bit typed,
                           input bit has_res, input sample_t want);
    sample_t s;
    bit      got;
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.move_length_ms <= len;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    got = profile_next(op, len, s);
    if (typed) begin
      if (has_res) sample_q.push_back(want);
    end else if (got) begin
      sample_q.push_back(s);
    end
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    case (index)
      CFG_LIN_TOP:  limits.lin_top = value;
      CFG_ANG_TOP:  limits.ang_top = value;
      CFG_LIN_UP:   limits.lin_up = value;
      CFG_LIN_DOWN: limits.lin_down = value;
      CFG_ANG_UP:   limits.ang_up = value;
      CFG_ANG_DOWN: limits.ang_down = value;
      default: ;
    endcase
  endtask

  // registers change only with the block drained and settled
  task automatic load_limits(input tvp_cfg_t v);
    in_ch.valid <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    write_reg(CFG_LIN_TOP, v.lin_top);
    write_reg(CFG_ANG_TOP, v.ang_top);
    write_reg(CFG_LIN_UP, v.lin_up);
    write_reg(CFG_LIN_DOWN, v.lin_down);
    write_reg(CFG_ANG_UP, v.ang_up);
    write_reg(CFG_ANG_DOWN, v.ang_down);
    cfg_ch.valid <= 1'b0;
  endtask

  // result side: check and ready pattern
  initial begin
    int unsigned hold;
    sample_t     got;
    sample_t     want;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.linear_velocity, out_ch.angular_velocity, out_ch.busy_res,
               out_ch.last_sample, out_ch.rejected};
        if (sample_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: lin %0d ang %0d busy %0b last %0b rej %0b",
                     got.lin, got.ang, got.busy, got.last, got.rej);
        end else begin
          want = sample_q.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("mismatch: exp lin %0d ang %0d busy %0b last %0b rej %0b, ",
                     want.lin, want.ang, want.busy, want.last, want.rej);
              $display("got lin %0d ang %0d busy %0b last %0b rej %0b",
                       got.lin, got.ang, got.busy, got.last, got.rej);
            end
          end
        end
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 16);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    stall_cnt = 0;
    while (stall_cnt < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        stall_cnt = 0;
      else
        stall_cnt++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin
    stim_row_t   rows [TABLE_ROWS];
    tvp_cfg_t    setting;
    logic [1:0]  op;
    logic [15:0] len;
    int unsigned words;

    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_TICK;
    in_ch.move_length_ms <= 16'd0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_LIN_TOP;
    cfg_ch.data <= 16'd0;
    rst <= 1'b1;
    quiet = 1'b0;
    calm = 1'b0;
    hold_req = 1'b0;
    mismatches = 0;
    limits = '0;
    ph = PH_IDLE;
    kind = OP_TICK;
    idx = 0;
    steps = 0;
    steady_left = 0;
    down_ms = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    setting = '0;
    setting.lin_top = 16'd4096;
    setting.ang_top = 16'hFFFF;
    setting.lin_up = 16'd200;
    setting.lin_down = 16'd300;
    load_limits(setting);

    rows[0]  = row(OP_TICK, 16'hFFFF, 1, 0, S_NONE);
    rows[1]  = row(OP_STRAIGHT, 16'd700, 1, 1, S_RUN0);
    rows[2]  = row(OP_CW, 16'd0, 1, 1, S_REJECT);
    rows[3]  = row(OP_TICK, 16'd0, 1, 1, S_RUN0);
    rows[4]  = row(OP_TICK, 16'h5555, 0, 0, S_NONE);
    rows[5]  = row(OP_TICK, 16'hAAAA, 1, 1, {17'sd4096, 17'sd0, 3'b100});
    rows[6]  = row(OP_TICK, 16'd0, 0, 0, S_NONE);
    rows[7]  = row(OP_TICK, 16'd0, 0, 0, S_NONE);
    rows[8]  = row(OP_TICK, 16'd0, 0, 0, S_NONE);
    rows[9]  = row(OP_TICK, 16'd0, 0, 0, S_NONE);
    rows[10] = row(OP_TICK, 16'd0, 0, 0, S_NONE);
    rows[11] = row(OP_TICK, 16'd0, 0, 0, S_NONE);
    rows[12] = row(OP_TICK, 16'd0, 1, 1, S_DONE);
    // turns with zero-step ramps, clockwise then counter-clockwise at full rate
    rows[13] = row(OP_CW, 16'd150, 1, 1, S_RUN0);
    rows[14] = row(OP_TICK, 16'd0, 1, 1, S_RUN0);
    rows[15] = row(OP_CCW, 16'hFFFF, 1, 1, S_REJECT);
    rows[16] = row(OP_TICK, 16'd0, 1, 1, {17'sd0, -17'sd65535, 3'b100});
    rows[17] = row(OP_TICK, 16'd0, 1, 1, {17'sd0, -17'sd65535, 3'b100});
    rows[18] = row(OP_TICK, 16'd0, 1, 1, S_RUN0);
    rows[19] = row(OP_TICK, 16'd0, 1, 1, S_DONE);
    rows[20] = row(OP_CCW, 16'd100, 1, 1, S_RUN0);
    rows[21] = row(OP_TICK, 16'd0, 1, 1, S_RUN0);
    rows[22] = row(OP_TICK, 16'd0, 1, 1, {17'sd0, 17'sd65535, 3'b100});
    rows[23] = row(OP_TICK, 16'd0, 1, 1, S_RUN0);
    rows[24] = row(OP_TICK, 16'd0, 1, 1, S_DONE);

    foreach (rows[i]) begin
      gap();
      send_word(rows[i].op, rows[i].len, rows[i].typed, rows[i].has_res, rows[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        setting = '0;
      end else if (p == 1) begin
        setting = '1;
      end else begin
        setting.lin_top = 16'($urandom);
        setting.ang_top = 16'($urandom);
        setting.lin_up = pick_ramp();
        setting.lin_down = pick_ramp();
        setting.ang_up = pick_ramp();
        setting.ang_down = pick_ramp();
      end
      load_limits(setting);
      quiet = (p == PHASES - 1);
      calm = 1'b0;
      if (p == 2) hold_req = 1'b1;
      words = 0;
      while (words < PHASE_WORDS || ph != PH_IDLE) begin
        if (words % 40 == 0) calm = ($urandom_range(0, 2) == 0);
        if (ph != PH_IDLE) begin
          op = ($urandom_range(0, 99) < 4) ? 2'($urandom_range(1, 3)) : OP_TICK;
          len = 16'($urandom);
          words++;
        end else if ($urandom_range(0, 99) < 12) begin
          op = OP_TICK;
          len = 16'($urandom);
        end else begin
          op = 2'($urandom_range(1, 3));
          len = ($urandom_range(0, 29) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
          words++;
        end
        gap();
        send_word(op, len, 0, 0, S_NONE);
      end
    end

    in_ch.valid <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
